### rtl/core/json_byte_tokenizer_macros.svh
// Assertion macros used by the tokenizer checker.
`ifndef JSON_BYTE_TOKENIZER_MACROS_SVH
`define JSON_BYTE_TOKENIZER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define JBT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("json tokenizer check failed");

// Check that cons holds in the cycle after ante.
`define JBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("json tokenizer check failed");

`endif

### rtl/core/jbt_pkg.sv
// Shared types, codes, byte constants and literal tables of the JSON byte tokenizer.
package jbt_pkg;

  // Width of the saturated integer accumulator, and of the integer result port.
  localparam int VALUE_WIDTH = 64;
  localparam int INT_WIDTH   = 64;

  // Depth of the queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [3:0] {
    KIND_NULL      = 4'd0,
    KIND_TRUE      = 4'd1,
    KIND_FALSE     = 4'd2,
    KIND_STR_BYTE  = 4'd3,
    KIND_STR_END   = 4'd4,
    KIND_INT       = 4'd5,
    KIND_FLOAT     = 4'd6,
    KIND_COLON     = 4'd7,
    KIND_COMMA     = 4'd8,
    KIND_OBRACE    = 4'd9,
    KIND_CBRACE    = 4'd10,
    KIND_OBRACKET  = 4'd11,
    KIND_CBRACKET  = 4'd12,
    KIND_NUM_BYTE  = 4'd13,
    KIND_ERROR     = 4'd14
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_UNICODE       = 3'd1,
    ERR_BAD_ESCAPE    = 3'd2,
    ERR_END_IN_STRING = 3'd3,
    ERR_UNKNOWN       = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    LIT_NULL  = 2'd0,
    LIT_TRUE  = 2'd1,
    LIT_FALSE = 2'd2
  } lit_e;

  // One result as it leaves the block.
  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             char_value;
    logic [INT_WIDTH-1:0]   int_value;
    err_e                   err;
  } token_t;

  // A second result never carries an integer value.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_value;
    err_e       err;
  } short_token_t;

  // Queue entry: the results of one request.
  typedef struct packed {
    logic         two;
    token_t       first;
    short_token_t second;
  } entry_t;

  // Byte constants.
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_E         = 8'h65;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_L         = 8'h6C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_S         = 8'h73;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  // Expected byte of a literal at a given position.
  function automatic logic [7:0] lit_byte(lit_e choice, logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (choice)
      LIT_NULL: begin
        unique case (idx)
          3'd0:    b = CH_N;
          3'd1:    b = CH_U;
          3'd2:    b = CH_L;
          3'd3:    b = CH_L;
          default: b = 8'h00;
        endcase
      end
      LIT_TRUE: begin
        unique case (idx)
          3'd0:    b = CH_T;
          3'd1:    b = CH_R;
          3'd2:    b = CH_U;
          3'd3:    b = CH_E;
          default: b = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (idx)
          3'd0:    b = CH_F;
          3'd1:    b = CH_A;
          3'd2:    b = CH_L;
          3'd3:    b = CH_S;
          3'd4:    b = CH_E;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Length of a literal in bytes.
  function automatic logic [2:0] lit_len(lit_e choice);
    logic [2:0] n;
    n = 3'd0;
    unique case (choice)
      LIT_NULL:  n = 3'd4;
      LIT_TRUE:  n = 3'd4;
      LIT_FALSE: n = 3'd5;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/core/jbt_front.sv
// Front of the tokenizer: lexer state, byte classification and result building.
module jbt_front import jbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       push_o,
  output entry_t     entry_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LIT,
    MODE_INT,
    MODE_FRAC,
    MODE_EXP,
    MODE_STR,
    MODE_ESC,
    MODE_ERR
  } mode_e;

  localparam logic [VALUE_WIDTH-1:0] ACC_LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] ACC_TENTH = ACC_LIMIT / 10;
  localparam logic [3:0]             ACC_REM   = 4'(ACC_LIMIT % 10);

  mode_e                  mode_q, mode_d;
  lit_e                   choice_q, choice_d;
  logic [2:0]             index_q, index_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   stopped_q, stopped_d;
  logic                   float_q, float_d;

  logic [7:0]             c;
  logic                   is_digit;
  logic                   is_sign;
  logic [3:0]             digit;
  logic [VALUE_WIDTH-1:0] acc_added;
  logic [VALUE_WIDTH-1:0] value_w;

  // Idle decode of the current byte
  logic         idle_has;
  short_token_t idle_tok;
  mode_e        idle_mode;
  logic         idle_num;
  logic         idle_lit;
  lit_e         idle_choice;

  // Result building
  logic         have0;
  logic         two;
  token_t       tok0;
  short_token_t tok1;
  logic         finish;
  logic         use_idle;
  logic [2:0]   index_inc;

  assign c        = text_byte_i;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
  assign digit    = c[3:0];
  assign index_inc = 3'(index_q + 3'd1);

  // Append one digit to the accumulator, pinning at the limit on overflow
  always_comb begin
    if ((acc_q > ACC_TENTH) || ((acc_q == ACC_TENTH) && (digit > ACC_REM))) begin
      acc_added = ACC_LIMIT;
    end else begin
      acc_added = (acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(digit);
    end
  end

  // Saturated signed value of the number so far
  always_comb begin
    if (neg_q) begin
      value_w = VALUE_WIDTH'(~acc_q + 1'b1);
    end else if (acc_q[VALUE_WIDTH-1]) begin
      value_w = ACC_LIMIT - 1'b1;
    end else begin
      value_w = acc_q;
    end
  end

  // Classify a byte seen between tokens
  always_comb begin
    idle_has        = 1'b0;
    idle_tok.kind   = KIND_NULL;
    idle_tok.char_value = 8'h00;
    idle_tok.err    = ERR_NONE;
    idle_mode       = MODE_IDLE;
    idle_num        = 1'b0;
    idle_lit        = 1'b0;
    idle_choice     = LIT_NULL;
    unique case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: idle_has = 1'b0;
      CH_COLON:    begin idle_has = 1'b1; idle_tok.kind = KIND_COLON;    end
      CH_COMMA:    begin idle_has = 1'b1; idle_tok.kind = KIND_COMMA;    end
      CH_LBRACE:   begin idle_has = 1'b1; idle_tok.kind = KIND_OBRACE;   end
      CH_RBRACE:   begin idle_has = 1'b1; idle_tok.kind = KIND_CBRACE;   end
      CH_LBRACKET: begin idle_has = 1'b1; idle_tok.kind = KIND_OBRACKET; end
      CH_RBRACKET: begin idle_has = 1'b1; idle_tok.kind = KIND_CBRACKET; end
      CH_QUOTE:    idle_mode = MODE_STR;
      CH_N: begin idle_lit = 1'b1; idle_choice = LIT_NULL;  idle_mode = MODE_LIT; end
      CH_T: begin idle_lit = 1'b1; idle_choice = LIT_TRUE;  idle_mode = MODE_LIT; end
      CH_F: begin idle_lit = 1'b1; idle_choice = LIT_FALSE; idle_mode = MODE_LIT; end
      default: begin
        if (is_sign || is_digit) begin
          idle_has            = 1'b1;
          idle_tok.kind       = KIND_NUM_BYTE;
          idle_tok.char_value = c;
          idle_num            = 1'b1;
          idle_mode           = MODE_INT;
        end else begin
          idle_has      = 1'b1;
          idle_tok.kind = KIND_ERROR;
          idle_tok.err  = ERR_UNKNOWN;
          idle_mode     = MODE_ERR;
        end
      end
    endcase
  end

  // Next state and results of one request
  always_comb begin
    mode_d    = mode_q;
    choice_d  = choice_q;
    index_d   = index_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    stopped_d = stopped_q;
    float_d   = float_q;

    have0           = 1'b0;
    two             = 1'b0;
    tok0.kind       = KIND_NULL;
    tok0.char_value = 8'h00;
    tok0.int_value  = '0;
    tok0.err        = ERR_NONE;
    tok1.kind       = KIND_NULL;
    tok1.char_value = 8'h00;
    tok1.err        = ERR_NONE;
    finish          = 1'b0;
    use_idle        = 1'b0;

    if (end_of_text_i) begin
      unique case (mode_q)
        MODE_INT, MODE_FRAC, MODE_EXP: finish = 1'b1;
        MODE_STR, MODE_ESC: begin
          have0     = 1'b1;
          tok0.kind = KIND_ERROR;
          tok0.err  = ERR_END_IN_STRING;
        end
        MODE_LIT: begin
          have0     = 1'b1;
          tok0.kind = KIND_ERROR;
          tok0.err  = ERR_UNKNOWN;
        end
        default: have0 = 1'b0;
      endcase
      mode_d    = MODE_IDLE;
      choice_d  = LIT_NULL;
      index_d   = 3'd0;
      neg_d     = 1'b0;
      acc_d     = '0;
      stopped_d = 1'b0;
      float_d   = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_IDLE: use_idle = 1'b1;
        MODE_LIT: begin
          if ((index_q < lit_len(choice_q)) && (c == lit_byte(choice_q, index_q))) begin
            index_d = index_inc;
            if (index_inc >= lit_len(choice_q)) begin
              have0     = 1'b1;
              tok0.kind = kind_e'({2'b00, choice_q});
              mode_d    = MODE_IDLE;
              index_d   = 3'd0;
              choice_d  = LIT_NULL;
            end
          end else begin
            have0     = 1'b1;
            tok0.kind = KIND_ERROR;
            tok0.err  = ERR_UNKNOWN;
            mode_d    = MODE_ERR;
          end
        end
        MODE_INT, MODE_FRAC, MODE_EXP: begin
          logic takes;
          takes = 1'b0;
          priority if ((mode_q == MODE_INT) && (c == CH_DOT)) begin
            takes   = 1'b1;
            mode_d  = MODE_FRAC;
            float_d = 1'b1;
          end else if ((mode_q != MODE_EXP) && (c == CH_E)) begin
            takes   = 1'b1;
            mode_d  = MODE_EXP;
            float_d = 1'b1;
          end else if (mode_q == MODE_FRAC) begin
            takes = is_digit;
          end else begin
            takes = is_sign || is_digit;
          end
          if (takes) begin
            if (!stopped_q) begin
              if (is_digit) begin
                acc_d = acc_added;
              end else begin
                stopped_d = 1'b1;
              end
            end
            have0           = 1'b1;
            tok0.kind       = KIND_NUM_BYTE;
            tok0.char_value = c;
          end else begin
            finish   = 1'b1;
            use_idle = 1'b1;
          end
        end
        MODE_STR: begin
          priority if (c == CH_BACKSLASH) begin
            mode_d = MODE_ESC;
          end else if (c == CH_QUOTE) begin
            have0     = 1'b1;
            tok0.kind = KIND_STR_END;
            mode_d    = MODE_IDLE;
          end else begin
            have0           = 1'b1;
            tok0.kind       = KIND_STR_BYTE;
            tok0.char_value = c;
          end
        end
        MODE_ESC: begin
          have0           = 1'b1;
          tok0.kind       = KIND_STR_BYTE;
          mode_d          = MODE_STR;
          unique case (c)
            CH_QUOTE, CH_SLASH, CH_BACKSLASH: tok0.char_value = c;
            CH_B: tok0.char_value = CH_BS;
            CH_F: tok0.char_value = CH_FF;
            CH_N: tok0.char_value = CH_LF;
            CH_R: tok0.char_value = CH_CR;
            CH_T: tok0.char_value = CH_TAB;
            CH_U: begin
              tok0.kind = KIND_ERROR;
              tok0.err  = ERR_UNICODE;
              mode_d    = MODE_ERR;
            end
            default: begin
              tok0.kind = KIND_ERROR;
              tok0.err  = ERR_BAD_ESCAPE;
              mode_d    = MODE_ERR;
            end
          endcase
        end
        default: have0 = 1'b0;
      endcase
    end

    // Close the number: emit its value and drop the number state
    if (finish) begin
      have0          = 1'b1;
      tok0.kind      = float_q ? KIND_FLOAT : KIND_INT;
      tok0.int_value = INT_WIDTH'($signed(value_w));
      mode_d         = MODE_IDLE;
      neg_d          = 1'b0;
      acc_d          = '0;
      stopped_d      = 1'b0;
      float_d        = 1'b0;
    end

    // Handle the byte as between tokens
    if (use_idle) begin
      mode_d = idle_mode;
      if (idle_num) begin
        neg_d     = (c == CH_MINUS);
        acc_d     = is_digit ? VALUE_WIDTH'(digit) : '0;
        stopped_d = 1'b0;
        float_d   = 1'b0;
      end
      if (idle_lit) begin
        choice_d = idle_choice;
        index_d  = 3'd1;
      end
      if (finish) begin
        two  = idle_has;
        tok1 = idle_tok;
      end else begin
        have0           = idle_has;
        tok0.kind       = idle_tok.kind;
        tok0.char_value = idle_tok.char_value;
        tok0.err        = idle_tok.err;
      end
    end
  end

  assign push_o         = accept_i && have0;
  assign entry_o.two    = two;
  assign entry_o.first  = tok0;
  assign entry_o.second = tok1;

  // Hold lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      choice_q  <= LIT_NULL;
      index_q   <= 3'd0;
      neg_q     <= 1'b0;
      acc_q     <= '0;
      stopped_q <= 1'b0;
      float_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      choice_q  <= choice_d;
      index_q   <= index_d;
      neg_q     <= neg_d;
      acc_q     <= acc_d;
      stopped_q <= stopped_d;
      float_q   <= float_d;
    end
  end

endmodule

### rtl/core/jbt_fifo.sv
// Short queue of result entries between the front and the back.
module jbt_fifo import jbt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  output logic   empty_o,
  input  logic   pop_i,
  output entry_t entry_o
);

  entry_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q;
  logic [FIFO_AW-1:0] rd_ptr_q;
  logic [FIFO_AW:0]   count_q;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : FIFO_AW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : FIFO_AW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= (FIFO_AW+1)'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= (FIFO_AW+1)'(count_q - 1'b1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### rtl/core/jbt_back.sv
// Back of the tokenizer: unpacks queue entries into single results on the output side.
module jbt_back import jbt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fifo_empty_i,
  input  entry_t               fifo_entry_i,
  output logic                 fifo_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [3:0]           token_kind_o,
  output logic [7:0]           char_value_o,
  output logic [INT_WIDTH-1:0] int_value_o,
  output logic [2:0]           error_code_o,
  output logic                 last_of_run_o
);

  entry_t cur_q;
  logic   cur_vld_q;
  logic   sub_q;
  logic   done;
  logic   last;
  logic   retire;
  logic   load;

  assign last    = sub_q || !cur_q.two;
  assign done    = cur_vld_q && pop_i;
  assign retire  = done && last;
  assign load    = (!cur_vld_q || retire) && !fifo_empty_i;
  assign fifo_pop_o = load;
  assign empty_o    = !cur_vld_q;

  // Select the result of the current entry
  always_comb begin
    if (sub_q) begin
      token_kind_o = cur_q.second.kind;
      char_value_o = cur_q.second.char_value;
      int_value_o  = '0;
      error_code_o = cur_q.second.err;
    end else begin
      token_kind_o = cur_q.first.kind;
      char_value_o = cur_q.first.char_value;
      int_value_o  = cur_q.first.int_value;
      error_code_o = cur_q.first.err;
    end
  end
  assign last_of_run_o = last;

  // Track the current entry and which of its results is shown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      sub_q     <= 1'b0;
    end else if (load) begin
      cur_vld_q <= 1'b1;
      sub_q     <= 1'b0;
    end else if (retire) begin
      cur_vld_q <= 1'b0;
      sub_q     <= 1'b0;
    end else if (done) begin
      sub_q <= 1'b1;
    end
  end

  // Hold the entry payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= fifo_entry_i;
    end
  end

endmodule

### rtl/core/json_byte_tokenizer.sv
// Top level of the JSON byte tokenizer: front, result queue and back.
// The tokenizer takes one byte of JSON text (or an end-of-text mark) per cycle
// whenever full is low, and never stalls on its own: the lexer state is updated
// in the cycle a request is taken, so a new byte can follow every cycle. Results
// pass through the queue into the output register and are shown there, the
// oldest first while empty is low. A byte that ends a number gives the int or
// float token and then the token of that byte, if any, one result per pop;
// every other request gives at most one. A four-entry queue between the lexer
// and the output register absorbs output stalls; once it and the output
// register are occupied, full rises until results are popped.
module json_byte_tokenizer import jbt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           text_byte_i,
  input  logic                 end_of_text_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [3:0]           token_kind_o,
  output logic [7:0]           char_value_o,
  output logic [INT_WIDTH-1:0] int_value_o,
  output logic [2:0]           error_code_o,
  output logic                 last_of_run_o
);

  logic   accept;
  logic   fe_push;
  entry_t fe_entry;
  logic   fifo_full;
  logic   fifo_empty;
  logic   fifo_pop;
  entry_t fifo_entry;

  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  jbt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (fe_push),
    .entry_o       (fe_entry)
  );

  jbt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .entry_i (fe_entry),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .pop_i   (fifo_pop),
    .entry_o (fifo_entry)
  );

  jbt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_empty_i  (fifo_empty),
    .fifo_entry_i  (fifo_entry),
    .fifo_pop_o    (fifo_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .token_kind_o  (token_kind_o),
    .char_value_o  (char_value_o),
    .int_value_o   (int_value_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### rtl/core/jbt_checker.sv
// Port-level checker of the JSON byte tokenizer and its bind to the top level.
`include "json_byte_tokenizer_macros.svh"

module jbt_checker import jbt_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input logic [7:0]           text_byte_i,
  input logic                 end_of_text_i,
  input logic                 empty,
  input logic                 pop,
  input logic [3:0]           token_kind_o,
  input logic [7:0]           char_value_o,
  input logic [INT_WIDTH-1:0] int_value_o,
  input logic [2:0]           error_code_o,
  input logic                 last_of_run_o
);

  // A waiting result holds until popped
  `JBT_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop, !empty && $stable(token_kind_o) && $stable(int_value_o) && $stable(last_of_run_o))

  // Only string and number bytes carry a character
  `JBT_ASSERT_NOW(a_char_only_bytes, clk_i, rst_ni, !empty && token_kind_o != KIND_STR_BYTE && token_kind_o != KIND_NUM_BYTE, char_value_o == 8'h00)

  // Only int and float tokens carry a value
  `JBT_ASSERT_NOW(a_value_only_numbers, clk_i, rst_ni, !empty && token_kind_o != KIND_INT && token_kind_o != KIND_FLOAT, int_value_o == '0)

  // Error code stays clear on all but error tokens
  `JBT_ASSERT_NOW(a_code_only_errors, clk_i, rst_ni, !empty && token_kind_o != KIND_ERROR, error_code_o == ERR_NONE)

  // An error is always the last result of its request and has a cause
  `JBT_ASSERT_NOW(a_error_closes_run, clk_i, rst_ni, !empty && token_kind_o == KIND_ERROR, last_of_run_o && error_code_o != ERR_NONE)

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (.*);

### tb/sv/tb_top.sv
// Self-checking testbench of the JSON byte tokenizer: a directed table, then random JSON text.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jbt_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 3;
  localparam int RANDOM_ITEMS   = 900;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [INT_WIDTH-1:0] MAG_LIMIT = INT_WIDTH'(1) << (VALUE_WIDTH - 1);
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_X       = 8'h78;

  typedef enum logic [2:0] {
    LX_IDLE, LX_LITERAL, LX_INTEGRAL, LX_FRACTION, LX_EXPONENT, LX_STRING, LX_ESCAPE, LX_ERROR
  } lex_mode_e;

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {FROM_PREDICTOR, NO_TOKEN, ONE_TOKEN} row_check_e;

  typedef struct {
    kind_e                kind;
    logic [7:0]           char_value;
    logic [INT_WIDTH-1:0] int_value;
    err_e                 err;
    logic                 last;
  } token_rec_t;

  typedef struct {
    logic [7:0] b;
    logic       eot;
    row_check_e chk;
    kind_e      kind;
    err_e       err;
  } stim_row_t;

  typedef struct {
    logic [7:0] b;
    logic       eot;
  } text_req_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 push          = 1'b0;
  logic                 pop           = 1'b0;
  logic [7:0]           text_byte_i   = 8'h00;
  logic                 end_of_text_i = 1'b0;
  logic                 full;
  logic                 empty;
  logic [3:0]           token_kind_o;
  logic [7:0]           char_value_o;
  logic [INT_WIDTH-1:0] int_value_o;
  logic [2:0]           error_code_o;
  logic                 last_of_run_o;

  json_byte_tokenizer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .token_kind_o  (token_kind_o),
    .char_value_o  (char_value_o),
    .int_value_o   (int_value_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Lexer state mirrored by the predictor
  lex_mode_e            lx_mode    = LX_IDLE;
  lit_e                 lit_sel    = LIT_NULL;
  logic [2:0]           lit_pos    = 3'd0;
  logic                 num_neg    = 1'b0;
  logic [INT_WIDTH-1:0] num_mag    = '0;
  logic                 num_stop   = 1'b0;
  logic                 num_dotted = 1'b0;

  string lit_word [3] = '{"null", "true", "false"};
  string esc_chars    = "\"/\\bfnrt";

  token_rec_t request_tokens[$];
  token_rec_t pending_tokens[$];
  text_req_t  text_q[$];

  int  n_items      = 0;
  int  n_dir_items  = 0;
  int  n_checked    = 0;
  int  n_numbers    = 0;
  int  n_saturated  = 0;
  int  n_errors     = 0;
  int  n_fail       = 0;
  int  burst_left   = 0;
  int  quiet_cycles = 0;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;

  // Directed table: extremes, bracket, number and string tokens, each error path
  stim_row_t dir_rows [26] = '{
    '{8'h00,        1'b1, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{8'h00,        1'b0, ONE_TOKEN,      KIND_ERROR,    ERR_UNKNOWN},
    '{8'hFF,        1'b1, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{CH_LBRACKET,  1'b0, ONE_TOKEN,      KIND_OBRACKET, ERR_NONE},
    '{CH_MINUS,     1'b0, FROM_PREDICTOR, KIND_NULL,     ERR_NONE},
    '{CH_NINE,      1'b0, FROM_PREDICTOR, KIND_NULL,     ERR_NONE},
    '{CH_DOT,       1'b0, FROM_PREDICTOR, KIND_NULL,     ERR_NONE},
    '{CH_UPPER_E,   1'b0, FROM_PREDICTOR, KIND_NULL,     ERR_NONE},
    '{8'h00,        1'b1, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{CH_QUOTE,     1'b0, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{8'hFF,        1'b0, FROM_PREDICTOR, KIND_NULL,     ERR_NONE},
    '{CH_BACKSLASH, 1'b0, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{CH_B,         1'b0, FROM_PREDICTOR, KIND_NULL,     ERR_NONE},
    '{CH_BACKSLASH, 1'b0, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{CH_U,         1'b0, ONE_TOKEN,      KIND_ERROR,    ERR_UNICODE},
    '{8'h00,        1'b1, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{CH_QUOTE,     1'b0, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{CH_BACKSLASH, 1'b0, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{CH_X,         1'b0, ONE_TOKEN,      KIND_ERROR,    ERR_BAD_ESCAPE},
    '{8'h00,        1'b1, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{CH_QUOTE,     1'b0, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{8'h00,        1'b1, ONE_TOKEN,      KIND_ERROR,    ERR_END_IN_STRING},
    '{CH_T,         1'b0, NO_TOKEN,       KIND_NULL,     ERR_NONE},
    '{8'h00,        1'b1, ONE_TOKEN,      KIND_ERROR,    ERR_UNKNOWN},
    '{CH_PLUS,      1'b0, FROM_PREDICTOR, KIND_NULL,     ERR_NONE},
    '{CH_RBRACE,    1'b0, FROM_PREDICTOR, KIND_NULL,     ERR_NONE}
  };

  function automatic void emit_token(kind_e k, logic [7:0] c, logic [INT_WIDTH-1:0] v, err_e e);
    token_rec_t t;
    t = '{kind: k, char_value: c, int_value: v, err: e, last: 1'b0};
    request_tokens.push_back(t);
  endfunction

  function automatic void raise_error(err_e e);
    emit_token(KIND_ERROR, 8'h00, '0, e);
    lx_mode = LX_ERROR;
  endfunction

  function automatic void clear_number();
    num_neg    = 1'b0;
    num_mag    = '0;
    num_stop   = 1'b0;
    num_dotted = 1'b0;
  endfunction

  function automatic void clear_lexer();
    lx_mode = LX_IDLE;
    lit_sel = LIT_NULL;
    lit_pos = 3'd0;
    clear_number();
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_sign_or_digit(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || is_digit(c);
  endfunction

  // Accumulate one decimal digit, pinned at the magnitude limit
  function automatic void add_digit(logic [7:0] c);
    logic [INT_WIDTH-1:0] d;
    d = INT_WIDTH'(c - CH_ZERO);
    if (num_mag > (MAG_LIMIT - d) / 10) num_mag = MAG_LIMIT;
    else num_mag = num_mag * 10 + d;
  endfunction

  // Close the number: emit int or float with the saturated value
  function automatic void close_number();
    logic [INT_WIDTH-1:0] v;
    if (num_neg) v = -num_mag;
    else if (num_mag >= MAG_LIMIT) v = MAG_LIMIT - 1;
    else v = num_mag;
    if (num_dotted) emit_token(KIND_FLOAT, 8'h00, v, ERR_NONE);
    else emit_token(KIND_INT, 8'h00, v, ERR_NONE);
    clear_number();
    lx_mode = LX_IDLE;
  endfunction

  // Advance the number syntax; return whether the byte still belongs to it
  function automatic bit number_takes(logic [7:0] c);
    case (lx_mode)
      LX_INTEGRAL: begin
        if (c == CH_DOT) begin
          lx_mode    = LX_FRACTION;
          num_dotted = 1'b1;
          return 1'b1;
        end
        if (c == CH_E) begin
          lx_mode    = LX_EXPONENT;
          num_dotted = 1'b1;
          return 1'b1;
        end
        return is_sign_or_digit(c);
      end
      LX_FRACTION: begin
        if (c == CH_E) begin
          lx_mode = LX_EXPONENT;
          return 1'b1;
        end
        return is_digit(c);
      end
      default: return is_sign_or_digit(c);
    endcase
  endfunction

  function automatic void idle_byte(logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
      CH_COLON:    emit_token(KIND_COLON, 8'h00, '0, ERR_NONE);
      CH_COMMA:    emit_token(KIND_COMMA, 8'h00, '0, ERR_NONE);
      CH_LBRACE:   emit_token(KIND_OBRACE, 8'h00, '0, ERR_NONE);
      CH_RBRACE:   emit_token(KIND_CBRACE, 8'h00, '0, ERR_NONE);
      CH_LBRACKET: emit_token(KIND_OBRACKET, 8'h00, '0, ERR_NONE);
      CH_RBRACKET: emit_token(KIND_CBRACKET, 8'h00, '0, ERR_NONE);
      CH_QUOTE:    lx_mode = LX_STRING;
      CH_N, CH_T, CH_F: begin
        if (c == CH_N) lit_sel = LIT_NULL;
        else if (c == CH_T) lit_sel = LIT_TRUE;
        else lit_sel = LIT_FALSE;
        lit_pos = 3'd1;
        lx_mode = LX_LITERAL;
      end
      default: begin
        if (is_sign_or_digit(c)) begin
          clear_number();
          if (c == CH_MINUS) num_neg = 1'b1;
          else if (c != CH_PLUS) add_digit(c);
          lx_mode = LX_INTEGRAL;
          emit_token(KIND_NUM_BYTE, c, '0, ERR_NONE);
        end else begin
          raise_error(ERR_UNKNOWN);
        end
      end
    endcase
  endfunction

  // Work out the tokens that one request causes, in order
  function automatic void tokenize_request(logic [7:0] c, logic eot);
    logic [7:0] t;
    if (eot) begin
      case (lx_mode)
        LX_INTEGRAL, LX_FRACTION, LX_EXPONENT: close_number();
        LX_STRING, LX_ESCAPE: emit_token(KIND_ERROR, 8'h00, '0, ERR_END_IN_STRING);
        LX_LITERAL: emit_token(KIND_ERROR, 8'h00, '0, ERR_UNKNOWN);
        default: ;
      endcase
      clear_lexer();
      return;
    end
    case (lx_mode)
      LX_IDLE: idle_byte(c);
      LX_LITERAL: begin
        if (int'(lit_pos) < lit_word[int'(lit_sel)].len() &&
            c == lit_word[int'(lit_sel)][int'(lit_pos)]) begin
          lit_pos = lit_pos + 3'd1;
          if (int'(lit_pos) >= lit_word[int'(lit_sel)].len()) begin
            // literal kinds share their codes with the literal choice
            emit_token(kind_e'({2'b00, lit_sel}), 8'h00, '0, ERR_NONE);
            lx_mode = LX_IDLE;
            lit_pos = 3'd0;
            lit_sel = LIT_NULL;
          end
        end else begin
          raise_error(ERR_UNKNOWN);
        end
      end
      LX_INTEGRAL, LX_FRACTION, LX_EXPONENT: begin
        if (number_takes(c)) begin
          // only the leading run of digits counts toward the value
          if (!num_stop) begin
            if (is_digit(c)) add_digit(c);
            else num_stop = 1'b1;
          end
          emit_token(KIND_NUM_BYTE, c, '0, ERR_NONE);
        end else begin
          close_number();
          idle_byte(c);
        end
      end
      LX_STRING: begin
        if (c == CH_BACKSLASH) lx_mode = LX_ESCAPE;
        else if (c == CH_QUOTE) begin
          emit_token(KIND_STR_END, 8'h00, '0, ERR_NONE);
          lx_mode = LX_IDLE;
        end else emit_token(KIND_STR_BYTE, c, '0, ERR_NONE);
      end
      LX_ESCAPE: begin
        case (c)
          CH_QUOTE, CH_SLASH, CH_BACKSLASH: t = c;
          CH_B: t = CH_BS;
          CH_F: t = CH_FF;
          CH_N: t = CH_LF;
          CH_R: t = CH_CR;
          CH_T: t = CH_TAB;
          default: t = 8'h00;
        endcase
        if (c == CH_U) raise_error(ERR_UNICODE);
        else if (t == 8'h00) raise_error(ERR_BAD_ESCAPE);
        else begin
          emit_token(KIND_STR_BYTE, t, '0, ERR_NONE);
          lx_mode = LX_STRING;
        end
      end
      default: ;
    endcase
  endfunction

  // Queue the tokens of an accepted request; a typed row replaces the prediction
  function automatic void record_request(logic [7:0] b, logic eot, row_check_e chk,
                                         kind_e k, err_e e);
    token_rec_t t;
    n_items++;
    request_tokens.delete();
    tokenize_request(b, eot);
    if (chk != FROM_PREDICTOR) begin
      request_tokens.delete();
      if (chk == ONE_TOKEN) emit_token(k, 8'h00, '0, e);
    end
    foreach (request_tokens[i]) begin
      t      = request_tokens[i];
      t.last = (i == request_tokens.size() - 1);
      pending_tokens.push_back(t);
    end
  endfunction

  function automatic void put(logic [7:0] b, logic eot);
    text_req_t r;
    r = '{b: b, eot: eot};
    text_q.push_back(r);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Append one random piece of JSON text, mostly well formed
  function automatic void queue_json_fragment();
    int    sel;
    int    n;
    string w;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: put(CH_SPACE, 1'b0);
          1: put(CH_TAB, 1'b0);
          2: put(CH_CR, 1'b0);
          default: put(CH_LF, 1'b0);
        endcase
      end
    end else if (sel < 30) begin
      case ($urandom_range(0, 5))
        0: put(CH_COLON, 1'b0);
        1: put(CH_COMMA, 1'b0);
        2: put(CH_LBRACE, 1'b0);
        3: put(CH_RBRACE, 1'b0);
        4: put(CH_LBRACKET, 1'b0);
        default: put(CH_RBRACKET, 1'b0);
      endcase
    end else if (sel < 42) begin
      w = lit_word[$urandom_range(0, 2)];
      if ($urandom_range(0, 7) == 0) begin
        // broken literal, usually closed right away
        n = $urandom_range(1, w.len() - 1);
        for (int i = 0; i < n; i++) put(w[i], 1'b0);
        put(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 3) != 0) put(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        for (int i = 0; i < w.len(); i++) put(w[i], 1'b0);
      end
    end else if (sel < 62) begin
      put(CH_QUOTE, 1'b0);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 18) begin
          put(CH_BACKSLASH, 1'b0);
          put(esc_chars[$urandom_range(0, esc_chars.len() - 1)], 1'b0);
        end else if (sel < 22) begin
          // unicode or random escape: stop the string and close the text
          put(CH_BACKSLASH, 1'b0);
          put(sel < 20 ? CH_U : 8'($urandom_range(0, 255)), 1'b0);
          put(8'($urandom_range(0, 255)), 1'b1);
          return;
        end else if (sel < 40) begin
          put(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          put(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
        end
      end
      if ($urandom_range(0, 15) == 0) put(8'($urandom_range(0, 255)), 1'b1);
      else put(CH_QUOTE, 1'b0);
    end else if (sel < 84) begin
      sel = $urandom_range(0, 11);
      if (sel < 4) put(CH_MINUS, 1'b0);
      else if (sel == 4) put(CH_PLUS, 1'b0);
      // long digit runs can drive the value into saturation
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 4);
      repeat (n) put(rand_digit(), 1'b0);
      if ($urandom_range(0, 4) == 0) begin
        put(CH_DOT, 1'b0);
        repeat ($urandom_range(1, 3)) put(rand_digit(), 1'b0);
      end
      if ($urandom_range(0, 4) == 0) begin
        put(CH_E, 1'b0);
        case ($urandom_range(0, 2))
          0: put(CH_PLUS, 1'b0);
          1: put(CH_MINUS, 1'b0);
          default: ;
        endcase
        repeat ($urandom_range(1, 2)) put(rand_digit(), 1'b0);
      end
      if ($urandom_range(0, 11) == 0)
        put($urandom_range(0, 1) ? CH_UPPER_E : CH_PLUS, 1'b0);
    end else if (sel < 92) begin
      put(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      put(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 3) != 0) put(8'($urandom_range(0, 255)), 1'b1);
    end
  endfunction

  // Offer one request in bursts with random gaps; return at the falling edge after acceptance
  task automatic send_item(logic [7:0] b, logic eot, row_check_e chk, kind_e k, err_e e);
    int r;
    int gap;
    if (burst_left == 0) begin
      r   = $urandom_range(0, 9);
      gap = (r < 3) ? 0 : (r < 8) ? $urandom_range(1, 3) : $urandom_range(4, 16);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    push          <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (full !== 1'b0) @(posedge clk_i);
    record_request(b, eot, chk, k, e);
    @(negedge clk_i);
  endtask

  // Hold the sender until every expected token has come out
  task automatic drain_tokens();
    push       <= 1'b0;
    burst_left  = 0;
    do @(negedge clk_i); while (pending_tokens.size() != 0);
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    text_req_t req;
    bit        drained;
    drained = 1'b0;
    clear_lexer();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].b, dir_rows[i].eot, dir_rows[i].chk, dir_rows[i].kind,
                dir_rows[i].err);
    n_dir_items = n_items;
    drain_tokens();

    while (n_items < n_dir_items + RANDOM_ITEMS) begin
      if (text_q.size() == 0) queue_json_fragment();
      req = text_q.pop_front();
      send_item(req.b, req.eot, FROM_PREDICTOR, KIND_NULL, ERR_NONE);
      if (n_items >= n_dir_items + 300) hold_req = 1'b1;
      if (!drained && n_items >= n_dir_items + 600) begin
        drain_tokens();
        drained = 1'b1;
      end
    end

    push <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d text requests (%0d from the directed table), %0d tokens checked,",
             n_items, n_dir_items, n_checked);
    $display("%0d numbers (%0d saturated), %0d error tokens, one %0d-cycle output hold-off.",
             n_numbers, n_saturated, n_errors, HOLD_CYCLES);
    if (n_fail == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Receiver: pop on changing patterns, with one long hold-off
  initial begin : receiver
    int pat;
    int span;
    bit toggle;
    pat    = 0;
    span   = 0;
    toggle = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (span == 0) begin
          pat  = $urandom_range(0, 4);
          span = $urandom_range(16, 96);
        end
        span--;
        toggle = ~toggle;
        case (pat)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 3) != 0);
          2: pop <= ($urandom_range(0, 3) == 0);
          3: pop <= toggle;
          default: pop <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
    if (want === got) return 0;
    $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
    return 1;
  endfunction

  // Compare each popped token with the oldest expectation
  always @(posedge clk_i) begin : check_tokens
    token_rec_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: token kind %0d arrived with none expected", $time, token_kind_o);
        n_fail++;
      end else begin
        want = pending_tokens.pop_front();
        n_fail += field_diff("token_kind", 64'(want.kind), 64'(token_kind_o));
        n_fail += field_diff("char_value", 64'(want.char_value), 64'(char_value_o));
        n_fail += field_diff("int_value", want.int_value, int_value_o);
        n_fail += field_diff("error_code", 64'(want.err), 64'(error_code_o));
        n_fail += field_diff("last_of_run", 64'(want.last), 64'(last_of_run_o));
        n_checked++;
        if (want.kind == KIND_INT || want.kind == KIND_FLOAT) begin
          n_numbers++;
          if (want.int_value == MAG_LIMIT || want.int_value == MAG_LIMIT - 1) n_saturated++;
        end
        if (want.kind == KIND_ERROR) n_errors++;
      end
    end
  end

  // End the run when no request moves on either side for too long
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, nothing accepted for %0d cycles", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
